// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the shader RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check cons in the same cycle as ante.
`define BRFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shader assertion failed");

// Check cons in the cycle after ante.
`define BRFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shader assertion failed");

`else

`define BRFS_ASSERT_NOW(label, clk, rst, ante, cons)
`define BRFS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/brfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Beam shader package
// Widths, register codes, reset values, fixed-point constants, shared types and div3.
// ----------------------------------------------------------------------------
package brfs_pkg;

   localparam int LED_COUNT_W = 11;
   localparam int LEVEL_W     = 16;
   localparam int MS_W        = 16;
   localparam int IDX_W       = 10;
   localparam int COLOR_W     = 8;
   localparam int C_W         = 10;   // n/3 for n < 2048
   localparam int QUO_W       = 17;   // Q1.16 distance, at most 1.0
   localparam int MUL_OP_W    = 17;
   localparam int MUL_PROD_W  = 2 * MUL_OP_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV3_W      = LED_COUNT_W + 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LED_COUNT = 2'd0,
      CSR_MAX_LEVEL = 2'd1,
      CSR_RISE_STEP = 2'd2,
      CSR_FALL_STEP = 2'd3
   } csr_index_type;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [LED_COUNT_W-1:0] RST_LED_COUNT = 11'd60;
   localparam logic [LEVEL_W-1:0]     RST_MAX_LEVEL = 16'd45875;
   localparam logic [LEVEL_W-1:0]     RST_RISE_STEP = 16'd164;
   localparam logic [LEVEL_W-1:0]     RST_FALL_STEP = 16'd234;

   localparam logic [MUL_OP_W-1:0] ONE_Q16     = 17'd65536;
   localparam logic [MUL_OP_W-1:0] FALLOFF_Q16 = 17'd45875;  // 0.7
   localparam logic [MUL_OP_W-1:0] BASE_R      = 17'd255;
   localparam logic [MUL_OP_W-1:0] BASE_G      = 17'd240;
   localparam logic [MUL_OP_W-1:0] BASE_B      = 17'd200;
   localparam logic [DIV3_W-1:0]   RECIP3      = 21'd683;    // ceil(2048/3)

   typedef struct packed {
      logic                load;
      logic [MUL_OP_W-1:0] a;
      logic [MUL_OP_W-1:0] b;
   } brfs_mul_op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } brfs_div_stat_type;

   // Exact floor(n/3) for every n below 2048.
   function automatic logic [C_W-1:0] div3(input logic [LED_COUNT_W-1:0] n);
      logic [DIV3_W-1:0] prod;
      prod = DIV3_W'(n) * RECIP3;
      return prod[DIV3_W-1:LED_COUNT_W];
   endfunction

endpackage

// ===== rtl/brfs_ifs.sv =====
// ----------------------------------------------------------------------------
// Beam shader channels
// Valid/ready interfaces for the request, response and register-write words.
// ----------------------------------------------------------------------------
interface brfs_req_if;
   import brfs_pkg::*;

   logic             valid;
   logic             ready;
   logic             func;
   logic             beam_on;
   logic [MS_W-1:0]  elapsed_ms;
   logic [IDX_W-1:0] led_index;

   modport source (output valid, func, beam_on, elapsed_ms, led_index, input ready);
   modport sink   (input valid, func, beam_on, elapsed_ms, led_index, output ready);
endinterface

interface brfs_rsp_if;
   import brfs_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic               painted;

   modport source (output valid, red, green, blue, painted, input ready);
   modport sink   (input valid, red, green, blue, painted, output ready);
endinterface

interface brfs_csr_if;
   import brfs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/brfs_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// One 17x17 unsigned multiply, product registered; reused by every step.
// ----------------------------------------------------------------------------
module brfs_mul (
   input  logic                             clock,
   input  brfs_pkg::brfs_mul_op_type        op,
   output logic [brfs_pkg::MUL_PROD_W-1:0]  prod
);
   import brfs_pkg::*;

   logic [MUL_PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (op.load) begin
         prod_ff <= MUL_PROD_W'(op.a) * MUL_PROD_W'(op.b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/brfs_div.sv =====
// ----------------------------------------------------------------------------
// Distance divider
// Restoring divider, one quotient bit a cycle: (num << 16) / den, num <= den.
// ----------------------------------------------------------------------------
module brfs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [brfs_pkg::C_W-1:0]    num,
   input  logic [brfs_pkg::C_W-1:0]    den,
   output logic [brfs_pkg::QUO_W-1:0]  quo,
   output brfs_pkg::brfs_div_stat_type stat
);
   import brfs_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [C_W:0]     rem_ff;
   logic [C_W-1:0]   den_ff;
   logic [QUO_W-1:0] quo_ff;

   logic             ge;
   logic [C_W:0]     rem_sub;
   logic [C_W:0]     rem_in;
   logic [QUO_W-1:0] quo_in;

   // Partial remainder stays below den after the subtract, so it fits C_W bits.
   always_comb begin
      ge      = rem_ff >= {1'b0, den_ff};
      rem_sub = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
      rem_in  = {rem_sub[C_W-1:0], 1'b0};
      quo_in  = {quo_ff[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (start) begin
            cnt_ff <= CNT_W'(QUO_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = cnt_ff != '0;
   assign stat.done = done_ff;

endmodule

// ===== rtl/beam_ramp_and_falloff_shader.sv =====
// ----------------------------------------------------------------------------
// Beam ramp and falloff shader
// Beam intensity ramp plus warm-white per-LED shading with edge falloff.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  carries one word per command: func 0 is a time tick, func 1 asks
//           for the color of LED led_index. Every word applies beam_on first;
//           turning the beam off clears the intensity.
//   rsp_if  returns one word per pixel request (red, green, blue, painted);
//           ticks return nothing.
//   csr_if  writes led_count, max_level, rise_step, fall_step (index 0..3);
//           always ready, write only while the block is idle.
// Timing: one word at a time; req_if.ready is low while a word is in work.
//   Tick: one multiply, then one update; the first tick after reset only
//   arms timing.
//   Pixel: square the level, apply the edge falloff, then scale red, green
//   and blue in turn; outer-third pixels first wait on the 17-step serial
//   divider for the edge distance. All products go through one shared
//   17x17 multiplier. Dark or out-of-strip pixels go straight to output.
// Reset: intensity 0, beam off, timing not started, registers to defaults.
// Stall: a result waits in the output register; the next request is still
//   taken, and its own result holds in the sequencer until rsp_if drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module beam_ramp_and_falloff_shader #(
   parameter int unsigned MAX_LEDS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   brfs_req_if.sink   req_if,
   brfs_rsp_if.source rsp_if,
   brfs_csr_if.sink   csr_if
);
   import brfs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_SMOOTH,
      S_DIV,
      S_FALL,
      S_LOCAL,
      S_RED,
      S_GREEN,
      S_BLUE,
      S_FINISH,
      S_OUT
   } state_type;

   // Configuration, with strip geometry precomputed at write time
   logic [LED_COUNT_W-1:0] n_ff;      // led_count clamped to MAX_LEDS
   logic [C_W-1:0]         c_ff;      // n/3
   logic [LED_COUNT_W-1:0] ce_ff;     // n - n/3
   logic [LEVEL_W-1:0]     max_ff;
   logic [LEVEL_W-1:0]     rise_ff;
   logic [LEVEL_W-1:0]     fall_ff;

   // Sequencer and ramp state
   state_type              state_ff;
   logic [LEVEL_W-1:0]     level_ff;
   logic                   beam_ff;
   logic                   timing_ff;
   logic                   edge_ff;
   logic [LEVEL_W-1:0]     smooth_ff;
   logic [MUL_OP_W-1:0]    falloff_ff;
   logic [LEVEL_W-1:0]     local_ff;
   logic [COLOR_W-1:0]     red_ff;
   logic [COLOR_W-1:0]     green_ff;
   logic [COLOR_W-1:0]     blue_ff;
   logic                   paint_ff;

   // Output register
   logic                   rsp_valid_ff;
   logic [COLOR_W-1:0]     rsp_red_ff;
   logic [COLOR_W-1:0]     rsp_green_ff;
   logic [COLOR_W-1:0]     rsp_blue_ff;
   logic                   rsp_paint_ff;

   logic                   accept;
   logic                   rsp_load;
   logic [LEVEL_W-1:0]     level_set;
   logic                   dark;
   logic                   outside;
   logic                   in_low;
   logic                   in_high;
   logic                   in_edge;
   logic [LED_COUNT_W-1:0] num_high;
   logic [C_W-1:0]         num;
   logic [LEVEL_W-1:0]     step_sel;
   logic                   div_start;
   logic [LEVEL_W:0]       sum;
   logic [LEVEL_W-1:0]     level_in;
   logic [LED_COUNT_W-1:0] n_in;

   brfs_mul_op_type        mul_op;
   logic [MUL_PROD_W-1:0]  prod;
   logic [QUO_W-1:0]       div_quo;
   brfs_div_stat_type      div_stat;

   // Clip a base*local product to one 8-bit channel.
   function automatic logic [COLOR_W-1:0] sat8(input logic [MUL_PROD_W-1:0] p);
      logic [MUL_PROD_W-17:0] v;
      v = p[MUL_PROD_W-1:16];
      return (|v[MUL_PROD_W-17:COLOR_W]) ? {COLOR_W{1'b1}} : v[COLOR_W-1:0];
   endfunction

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;
   // Move a finished word into the output register once it is free.
   assign rsp_load     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_if.ready);

   // Apply beam_on ahead of the command; clear level on an on-to-off change.
   always_comb begin
      level_set = (beam_ff && !req_if.beam_on) ? '0 : level_ff;
      dark      = !req_if.beam_on && (level_set == '0);
      outside   = (n_ff == '0) || (LED_COUNT_W'(req_if.led_index) >= n_ff);
      in_low    = req_if.led_index < IDX_W'(c_ff);
      in_high   = LED_COUNT_W'(req_if.led_index) > ce_ff;
      in_edge   = (c_ff != '0) && (in_low || in_high);
      num_high  = LED_COUNT_W'(req_if.led_index) - ce_ff;
      num       = in_low ? (c_ff - C_W'(req_if.led_index)) : num_high[C_W-1:0];
      step_sel  = req_if.beam_on ? rise_ff : fall_ff;
      div_start = accept && (req_if.func == FUNC_PIXEL) && !dark && !outside && in_edge;
   end

   // Ramp update from the registered ms*step product.
   always_comb begin
      sum = {1'b0, level_ff} + {1'b0, prod[LEVEL_W-1:0]};
      if (beam_ff) begin
         if ((|prod[MUL_PROD_W-1:LEVEL_W]) || (sum > {1'b0, max_ff})) begin
            level_in = max_ff;
         end else begin
            level_in = sum[LEVEL_W-1:0];
         end
      end else begin
         if (prod >= MUL_PROD_W'(level_ff)) begin
            level_in = '0;
         end else begin
            level_in = level_ff - prod[LEVEL_W-1:0];
         end
      end
   end

   // Operand select for the shared multiplier
   always_comb begin
      mul_op = '0;
      unique case (state_ff)
         S_IDLE: begin
            mul_op.load = accept;
            if (req_if.func == FUNC_PIXEL) begin
               mul_op.a = MUL_OP_W'(level_set);
               mul_op.b = MUL_OP_W'(level_set);
            end else begin
               mul_op.a = MUL_OP_W'(req_if.elapsed_ms);
               mul_op.b = MUL_OP_W'(step_sel);
            end
         end
         S_DIV: begin
            mul_op.load = div_stat.done;
            mul_op.a    = div_quo;
            mul_op.b    = FALLOFF_Q16;
         end
         S_LOCAL: begin
            mul_op.load = 1'b1;
            mul_op.a    = MUL_OP_W'(smooth_ff);
            mul_op.b    = falloff_ff;
         end
         S_RED: begin
            mul_op.load = 1'b1;
            mul_op.a    = BASE_R;
            mul_op.b    = MUL_OP_W'(prod[31:16]);
         end
         S_GREEN: begin
            mul_op.load = 1'b1;
            mul_op.a    = BASE_G;
            mul_op.b    = MUL_OP_W'(local_ff);
         end
         S_BLUE: begin
            mul_op.load = 1'b1;
            mul_op.a    = BASE_B;
            mul_op.b    = MUL_OP_W'(local_ff);
         end
         default: begin
            mul_op = '0;
         end
      endcase
   end

   brfs_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   brfs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (c_ff),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   // Register writes; clamp the strip length and derive its thirds.
   assign n_in = (32'(csr_if.data[LED_COUNT_W-1:0]) > MAX_LEDS) ?
                 LED_COUNT_W'(MAX_LEDS) : csr_if.data[LED_COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= RST_LED_COUNT;
         c_ff    <= div3(RST_LED_COUNT);
         ce_ff   <= RST_LED_COUNT - LED_COUNT_W'(div3(RST_LED_COUNT));
         max_ff  <= RST_MAX_LEVEL;
         rise_ff <= RST_RISE_STEP;
         fall_ff <= RST_FALL_STEP;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_LED_COUNT: begin
               n_ff  <= n_in;
               c_ff  <= div3(n_in);
               ce_ff <= n_in - LED_COUNT_W'(div3(n_in));
            end
            CSR_MAX_LEVEL: max_ff  <= csr_if.data;
            CSR_RISE_STEP: rise_ff <= csr_if.data;
            CSR_FALL_STEP: fall_ff <= csr_if.data;
         endcase
      end
   end

   // Sequencer, ramp state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         beam_ff      <= 1'b0;
         timing_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  beam_ff  <= req_if.beam_on;
                  level_ff <= level_set;
                  if (req_if.func == FUNC_TICK) begin
                     // first tick only arms timing
                     if (!timing_ff) begin
                        timing_ff <= 1'b1;
                     end else begin
                        state_ff <= S_TICK;
                     end
                  end else if (dark || outside) begin
                     red_ff   <= '0;
                     green_ff <= '0;
                     blue_ff  <= '0;
                     paint_ff <= 1'b0;
                     state_ff <= S_OUT;
                  end else begin
                     edge_ff  <= in_edge;
                     state_ff <= S_SMOOTH;
                  end
               end
            end
            S_TICK: begin
               level_ff <= level_in;
               state_ff <= S_IDLE;
            end
            S_SMOOTH: begin
               smooth_ff <= prod[31:16];
               if (edge_ff) begin
                  state_ff <= S_DIV;
               end else begin
                  falloff_ff <= ONE_Q16;
                  state_ff   <= S_LOCAL;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_FALL;
               end
            end
            S_FALL: begin
               falloff_ff <= ONE_Q16 - prod[32:16];
               state_ff   <= S_LOCAL;
            end
            S_LOCAL: begin
               state_ff <= S_RED;
            end
            S_RED: begin
               local_ff <= prod[31:16];
               state_ff <= S_GREEN;
            end
            S_GREEN: begin
               red_ff   <= sat8(prod);
               state_ff <= S_BLUE;
            end
            S_BLUE: begin
               green_ff <= sat8(prod);
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               blue_ff  <= sat8(prod);
               paint_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold until the output register is free
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_red_ff   <= red_ff;
         rsp_green_ff <= green_ff;
         rsp_blue_ff  <= blue_ff;
         rsp_paint_ff <= paint_ff;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.red     = rsp_red_ff;
   assign rsp_if.green   = rsp_green_ff;
   assign rsp_if.blue    = rsp_blue_ff;
   assign rsp_if.painted = rsp_paint_ff;

   // A rising ramp never leaves the level above the ceiling.
   `BRFS_ASSERT_NEXT(a_ramp_ceiling, clock, reset, (state_ff == S_TICK) && beam_ff, level_ff <= max_ff)
   // The divider is never still running when a new word comes in.
   `BRFS_ASSERT_NOW(a_div_idle_on_accept, clock, reset, accept, !div_stat.busy)
   // Divider completion is only seen while the sequencer waits for it.
   `BRFS_ASSERT_NOW(a_div_done_in_wait, clock, reset, div_stat.done, state_ff == S_DIV)
   // A painted result never comes from a dark beam.
   `BRFS_ASSERT_NOW(a_paint_lit, clock, reset, (state_ff == S_OUT) && paint_ff, beam_ff || (level_ff != '0))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beam shader testbench
// Sends tick and pixel words through the shader and checks each color word
// against an in-bench model of the intensity ramp and the edge falloff.
// ----------------------------------------------------------------------------
module tb;
   import brfs_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off to back up the block
   localparam int SETTLE_CYCLES   = 30;    // covers a trailing tick or a slow pixel
   localparam int STALL_LIMIT     = 3000;  // cycles with no handshake at all
   localparam int REPORT_LIMIT    = 10;

   // One request word and one color word, laid out as the channels carry them.
   typedef struct packed {
      logic             func;
      logic             beam_on;
      logic [MS_W-1:0]  elapsed_ms;
      logic [IDX_W-1:0] led_index;
   } shade_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               painted;
   } color_type;

   // Tracks the beam state and registers, predicts each color word and
   // compares what comes back in order.
   class shade_scoreboard;
      logic [LED_COUNT_W-1:0] strip_leds;
      logic [LEVEL_W-1:0]     level_cap;
      logic [LEVEL_W-1:0]     rise_per_ms;
      logic [LEVEL_W-1:0]     fall_per_ms;
      logic [LEVEL_W-1:0]     level;
      logic                   beam_lit;
      logic                   timing_armed;
      color_type              pending_colors[$];
      int                     mismatches;

      function new();
         strip_leds   = RST_LED_COUNT;
         level_cap    = RST_MAX_LEVEL;
         rise_per_ms  = RST_RISE_STEP;
         fall_per_ms  = RST_FALL_STEP;
         level        = '0;
         beam_lit     = 1'b0;
         timing_armed = 1'b0;
         mismatches   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LED_COUNT: strip_leds  = data[LED_COUNT_W-1:0];
            CSR_MAX_LEVEL: level_cap   = data;
            CSR_RISE_STEP: rise_per_ms = data;
            CSR_FALL_STEP: fall_per_ms = data;
            default: ;
         endcase
      endfunction

      function void ramp_tick(logic [MS_W-1:0] ms);
         logic [63:0] delta;
         logic [63:0] sum;
         delta = 64'(ms) * 64'(beam_lit ? rise_per_ms : fall_per_ms);
         if (!timing_armed) begin
            timing_armed = 1'b1;
            return;
         end
         if (beam_lit) begin
            sum = 64'(level) + delta;
            if (sum > 64'(level_cap)) sum = 64'(level_cap);
            level = sum[LEVEL_W-1:0];
         end else if (delta >= 64'(level)) begin
            level = '0;
         end else begin
            level = level - delta[LEVEL_W-1:0];
         end
      endfunction

      function logic [COLOR_W-1:0] scale_base(logic [63:0] base, logic [63:0] shade);
         logic [63:0] v;
         v = (base * shade) >> 16;
         return (v > 64'd255) ? 8'd255 : v[COLOR_W-1:0];
      endfunction

      function color_type pixel_color(logic [IDX_W-1:0] idx);
         logic [63:0] n;
         logic [63:0] c;
         logic [63:0] ce;
         logic [63:0] reach;
         logic [63:0] falloff;
         logic [63:0] smooth;
         logic [63:0] shade;
         color_type   col;
         col = '0;
         n = (strip_leds > 11'd1024) ? 64'd1024 : 64'(strip_leds);
         if (!beam_lit && level == '0) return col;
         if (n == 0 || 64'(idx) >= n) return col;
         c = n / 3;
         ce = n - c;
         falloff = 64'(ONE_Q16);
         // Outer thirds: distance from the center band, as a fraction of c.
         if (c != 0 && (64'(idx) < c || 64'(idx) > ce)) begin
            reach = (64'(idx) < c) ? c - 64'(idx) : 64'(idx) - ce;
            reach = (reach << 16) / c;
            if (reach > 64'(ONE_Q16)) reach = 64'(ONE_Q16);
            falloff = 64'(ONE_Q16) - ((reach * 64'(FALLOFF_Q16)) >> 16);
         end
         smooth = (64'(level) * 64'(level)) >> 16;
         shade = (smooth * falloff) >> 16;
         col.red     = scale_base(64'(BASE_R), shade);
         col.green   = scale_base(64'(BASE_G), shade);
         col.blue    = scale_base(64'(BASE_B), shade);
         col.painted = 1'b1;
         return col;
      endfunction

      // Apply the beam bit first, then the tick or the pixel request.
      function void note_word(shade_req_type w);
         if (w.beam_on != beam_lit) begin
            beam_lit = w.beam_on;
            if (!w.beam_on) level = '0;
         end
         if (w.func == FUNC_TICK) ramp_tick(w.elapsed_ms);
         else pending_colors.push_back(pixel_color(w.led_index));
      endfunction

      function void report_mismatch(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
      endfunction

      function void check_result(color_type got);
         color_type want;
         if (pending_colors.size() == 0) begin
            report_mismatch($sformatf("color word with none pending: r=%0d g=%0d b=%0d p=%0d",
                                      got.red, got.green, got.blue, got.painted));
            return;
         end
         want = pending_colors.pop_front();
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.painted !== want.painted)
            report_mismatch($sformatf(
               "color word: expected r=%0d g=%0d b=%0d p=%0d, got r=%0d g=%0d b=%0d p=%0d",
               want.red, want.green, want.blue, want.painted,
               got.red, got.green, got.blue, got.painted));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   brfs_req_if req_if ();
   brfs_rsp_if rsp_if ();
   brfs_csr_if csr_if ();

   beam_ramp_and_falloff_shader #(
      .MAX_LEDS (1024)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   shade_scoreboard board;
   int strip_len;          // effective strip length of the current setting
   bit quiet;              // final stretch: no gaps on either side
   bit hold_request;       // ask the receiver for one long hold-off
   int idle_cycles = 0;

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sample every handshake at the rising edge and feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            board.write_reg(csr_index_type'(csr_if.index), csr_if.data);
         if (req_if.valid && req_if.ready)
            board.note_word({req_if.func, req_if.beam_on, req_if.elapsed_ms, req_if.led_index});
         if (rsp_if.valid && rsp_if.ready)
            board.check_result({rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.painted});
      end
   end

   // Watchdog: end the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: alternate random open and stalled bursts, one long hold-off on
   // request, always open in the final stretch.
   initial begin : rsp_ready_gen
      int  run;
      bit  grant;
      rsp_if.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            run = HOLD_CYCLES;
            grant = 1'b0;
         end else if (quiet) begin
            run = 1;
            grant = 1'b1;
         end else begin
            run = $urandom_range(1, 17);
            grant = ($urandom_range(0, 2) != 0);
         end
         repeat (run) begin
            @(negedge clock);
            rsp_if.ready <= grant;
         end
      end
   end

   function automatic shade_req_type tick_word(bit on, int ms);
      shade_req_type w;
      w.func       = FUNC_TICK;
      w.beam_on    = on;
      w.elapsed_ms = MS_W'(ms);
      w.led_index  = '0;
      return w;
   endfunction

   function automatic shade_req_type pixel_word(bit on, int idx);
      shade_req_type w;
      w.func       = FUNC_PIXEL;
      w.beam_on    = on;
      w.elapsed_ms = MS_W'($urandom);
      w.led_index  = IDX_W'(idx);
      return w;
   endfunction

   // Mostly lit-beam traffic with short ticks so the ramp climbs, pixels
   // biased to the falloff band edges, plus wide noise on every field.
   function automatic shade_req_type random_word();
      shade_req_type w;
      int            c;
      int            pick;
      w.func    = ($urandom_range(0, 9) < 6) ? FUNC_PIXEL : FUNC_TICK;
      w.beam_on = ($urandom_range(0, 11) != 0);
      case ($urandom_range(0, 9))
         0:       w.elapsed_ms = '0;
         1:       w.elapsed_ms = MS_W'($urandom);
         2:       w.elapsed_ms = '1;
         default: w.elapsed_ms = MS_W'($urandom_range(1, 60));
      endcase
      c = strip_len / 3;
      case ($urandom_range(0, 7))
         0: w.led_index = IDX_W'($urandom);
         1, 2: begin
            case ($urandom_range(0, 5))
               0:       pick = c - 1;
               1:       pick = c;
               2:       pick = strip_len - c;
               3:       pick = strip_len - c + 1;
               4:       pick = 0;
               default: pick = strip_len - 1;
            endcase
            w.led_index = (pick < 0) ? '0 : IDX_W'(pick);
         end
         default: begin
            if (strip_len == 0) w.led_index = IDX_W'($urandom);
            else w.led_index = IDX_W'($urandom_range(0, strip_len - 1));
         end
      endcase
      return w;
   endfunction

   // Offer one word, with an occasional random gap first; hold until taken.
   task automatic send_word(input shade_req_type w);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= w.func;
      req_if.beam_on    <= w.beam_on;
      req_if.elapsed_ms <= w.elapsed_ms;
      req_if.led_index  <= w.led_index;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   // Write all four registers; the block must be idle.
   task automatic configure(input int leds, input int cap, input int rise, input int fall);
      write_csr(CSR_LED_COUNT, leds);
      write_csr(CSR_MAX_LEVEL, cap);
      write_csr(CSR_RISE_STEP, rise);
      write_csr(CSR_FALL_STEP, fall);
      csr_if.valid <= 1'b0;
      strip_len = ((leds & 'h7FF) > 1024) ? 1024 : (leds & 'h7FF);
   endtask

   // Drop valid, wait for every pending color word, then let a trailing tick
   // finish before anything else touches the block.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending_colors.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      repeat (count) send_word(random_word());
   endtask

   initial begin
      int errors;
      board = new();
      quiet = 1'b0;
      hold_request = 1'b0;
      strip_len = RST_LED_COUNT;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.func       <= FUNC_TICK;
      req_if.beam_on    <= 1'b0;
      req_if.elapsed_ms <= '0;
      req_if.led_index  <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_LED_COUNT;
      csr_if.data       <= '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed words on the reset settings: 60 LEDs, center band 20..40.
      send_word(pixel_word(0, 5));          // beam dark
      send_word(tick_word(1, 500));         // first tick only arms timing
      send_word(pixel_word(1, 30));         // lit but zero intensity
      send_word(tick_word(1, 65535));       // ramp clamps at max_level
      send_word(pixel_word(1, 0));          // far edge, full falloff
      send_word(pixel_word(1, 19));
      send_word(pixel_word(1, 20));         // center band boundaries
      send_word(pixel_word(1, 40));
      send_word(pixel_word(1, 41));
      send_word(pixel_word(1, 59));
      send_word(pixel_word(1, 60));         // just outside the strip
      send_word(pixel_word(1, 1023));
      send_word(tick_word(0, 10));          // beam off clears, ramp down at zero
      send_word(pixel_word(0, 30));
      send_word(tick_word(1, 1));
      send_word(tick_word(1, 0));
      send_word(pixel_word(1, 30));
      send_word(tick_word(1, 100));
      send_word(pixel_word(1, 45));
      send_word(pixel_word(0, 45));         // pixel word turns the beam off
      send_word(tick_word(0, 65535));       // ramp down saturates at zero
      send_word(tick_word(1, 682));
      send_word(pixel_word(1, 10));
      drain();

      // Largest strip, widest steps; the receiver holds off to back up input.
      configure(1024, 65535, 65535, 65535);
      hold_request = 1'b1;
      random_phase(ITEMS_PER_PHASE);
      send_word(tick_word(1, 65535));       // leave the intensity at full scale
      drain();

      // Oversized strip count (all bits set) and a lowered ceiling: the first
      // lit tick pulls the intensity down to it.
      configure('hFFFF, 1000, 7, 11);
      send_word(tick_word(1, 0));
      send_word(pixel_word(1, 0));
      random_phase(ITEMS_PER_PHASE);
      drain();

      configure(0, 30000, 300, 300);        // empty strip, nothing painted
      random_phase(ITEMS_PER_PHASE);
      drain();

      configure(1, 65535, 1, 0);
      random_phase(ITEMS_PER_PHASE);
      drain();

      configure(2, 45875, 164, 234);        // no outer thirds
      random_phase(ITEMS_PER_PHASE);
      drain();

      configure(3, 20000, 50, 65535);
      random_phase(ITEMS_PER_PHASE);
      drain();

      repeat (2) begin
         configure($urandom_range(1, 1024), $urandom_range(0, 65535),
                   $urandom_range(0, 2000), $urandom_range(0, 65535));
         random_phase(ITEMS_PER_PHASE);
         drain();
      end

      // Final stretch at full rate on both sides.
      quiet = 1'b1;
      configure(100, 45875, 164, 234);
      random_phase(ITEMS_PER_PHASE);
      drain();

      errors = board.mismatches + board.pending_colors.size();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/brfs_pkg.sv
rtl/brfs_ifs.sv
rtl/brfs_mul.sv
rtl/brfs_div.sv
rtl/beam_ramp_and_falloff_shader.sv
tb/tb.sv
